@@ rtl/core/rts_pkg.sv @@
// ----------------------------------------------------------------------------
// rts_pkg
// Shared types and constants for the record trailer strip block.
// ----------------------------------------------------------------------------
package rts_pkg;

   localparam int RECORD_BYTES_DEF     = 8192;
   localparam int MAX_VARINT_BYTES_DEF = 5;
   localparam int JOB_QUEUE_DEPTH      = 2;

   localparam int FLAGS_W   = 16;
   localparam int PAYLOAD_W = 14;
   localparam int OVERLAP_W = 2;
   localparam int STATUS_W  = 2;
   localparam int VARINT_DIGIT_W = 7;

   localparam logic [3:0] TOP_FLAG_BIT    = 4'd15;
   localparam logic [3:0] LAST_ENTRY_BIT  = 4'd1;
   localparam int         OVERLAP_FLAG_BIT = 0;
   localparam int         VARINT_END_BIT   = 7;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_TRAILER_LONG = 2'd1,
      ST_BEFORE_START = 2'd2,
      ST_OVERFLOW     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      W_IDLE,
      W_SCAN,
      W_VREAD,
      W_VUSE,
      W_VCHECK,
      W_OVL,
      W_OVL_USE
   } walk_state_type;

endpackage

@@ rtl/core/rts_store.sv @@
// ----------------------------------------------------------------------------
// rts_store
// Record byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rts_store #(
   parameter int RECORD_BYTES = rts_pkg::RECORD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(RECORD_BYTES)-1:0] wr_addr,
   input  logic [7:0]                      wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(RECORD_BYTES)-1:0] rd_addr,
   output logic [7:0]                      rd_data
);
   import rts_pkg::*;

   logic [7:0] mem [RECORD_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/rts_job_fifo.sv @@
// ----------------------------------------------------------------------------
// rts_job_fifo
// Short queue of finished-record jobs between the loader and the walker.
// ----------------------------------------------------------------------------
module rts_job_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = rts_pkg::JOB_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);
   import rts_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/rts_loader.sv @@
// ----------------------------------------------------------------------------
// rts_loader
// Front end: accept record bytes, write them to the store, count the length
// and queue a job at the last byte.
// ----------------------------------------------------------------------------
module rts_loader #(
   parameter int RECORD_BYTES = rts_pkg::RECORD_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last_byte,
   output logic                              wr_en,
   output logic [$clog2(RECORD_BYTES)-1:0]   wr_addr,
   output logic [7:0]                        wr_data,
   output logic                              job_push,
   output logic [$clog2(RECORD_BYTES+1)-1:0] job_length,
   output logic                              job_overflow,
   input  logic                              queue_empty,
   input  logic                              walk_idle
);
   import rts_pkg::*;

   localparam int LEN_W  = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_W = $clog2(RECORD_BYTES);

   logic [LEN_W-1:0] length_ff, length_in;
   logic             overflow_ff, overflow_in;
   logic             wait_ff, wait_in;
   logic             accept, room;
   logic [LEN_W-1:0] length_next;
   logic             overflow_next;

   assign req_stall = wait_ff;
   assign accept    = req_valid && !wait_ff;
   assign room      = (length_ff < LEN_W'(RECORD_BYTES));

   assign wr_en   = accept && room;
   assign wr_addr = length_ff[ADDR_W-1:0];
   assign wr_data = req_data_byte;

   assign length_next   = room ? length_ff + 1'b1 : length_ff;
   assign overflow_next = overflow_ff || !room;

   assign job_push     = accept && req_last_byte;
   assign job_length   = length_next;
   assign job_overflow = overflow_next;

   always_comb begin
      length_in   = length_ff;
      overflow_in = overflow_ff;
      wait_in     = wait_ff;
      if (wait_ff && queue_empty && walk_idle) begin
         wait_in = 1'b0;
      end
      if (accept) begin
         if (req_last_byte) begin
            // hold off new bytes until the walker has finished reading
            length_in   = '0;
            overflow_in = 1'b0;
            wait_in     = 1'b1;
         end else begin
            length_in   = length_next;
            overflow_in = overflow_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         overflow_ff <= 1'b0;
         wait_ff     <= 1'b0;
      end else begin
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
         wait_ff     <= wait_in;
      end
   end

endmodule

@@ rtl/core/rts_walker.sv @@
// ----------------------------------------------------------------------------
// rts_walker
// Back end: walk back from the record end, strip trailing entries and the
// overlap entry, and hold the result in an output register.
// ----------------------------------------------------------------------------
module rts_walker #(
   parameter int RECORD_BYTES     = rts_pkg::RECORD_BYTES_DEF,
   parameter int MAX_VARINT_BYTES = rts_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rts_pkg::FLAGS_W-1:0]       flags,
   input  logic                              job_valid,
   input  logic [$clog2(RECORD_BYTES+1)-1:0] job_length,
   input  logic                              job_overflow,
   output logic                              job_pop,
   output logic                              rd_en,
   output logic [$clog2(RECORD_BYTES)-1:0]   rd_addr,
   input  logic [7:0]                        rd_data,
   output logic                              walk_idle,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rts_pkg::PAYLOAD_W-1:0]     rsp_payload_length,
   output logic [rts_pkg::OVERLAP_W-1:0]     rsp_overlap_length,
   output rts_pkg::status_type               rsp_status
);
   import rts_pkg::*;

   localparam int LEN_W  = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_W = $clog2(RECORD_BYTES);
   localparam int TE_W   = VARINT_DIGIT_W * MAX_VARINT_BYTES;
   localparam int CMP_W  = (TE_W > LEN_W) ? TE_W : LEN_W;
   localparam int K_W    = $clog2(MAX_VARINT_BYTES + 1);

   walk_state_type        state_ff, state_in;
   logic [3:0]            bit_ff, bit_in;
   logic [LEN_W-1:0]      size_ff, size_in;
   logic [TE_W-1:0]       te_ff, te_in;
   logic [K_W-1:0]        k_ff, k_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PAYLOAD_W-1:0]  out_len_ff, out_len_in;
   logic [OVERLAP_W-1:0]  out_ovl_ff, out_ovl_in;
   status_type            out_st_ff, out_st_in;

   logic                  fin;
   status_type            fin_st;
   logic [LEN_W-1:0]      fin_size;
   logic [OVERLAP_W-1:0]  fin_ovl;
   logic [5:0]            shamt;
   logic [TE_W-1:0]       te_next;

   assign shamt   = 6'(VARINT_DIGIT_W * (32'(k_ff) - 1));
   assign te_next = te_ff | (TE_W'(rd_data[VARINT_DIGIT_W-1:0]) << shamt);

   always_comb begin
      state_in = state_ff;
      bit_in   = bit_ff;
      size_in  = size_ff;
      te_in    = te_ff;
      k_in     = k_ff;
      job_pop  = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = '0;
      fin      = 1'b0;
      fin_st   = ST_OK;
      fin_size = size_ff;
      fin_ovl  = '0;

      unique case (state_ff)
         W_IDLE: begin
            if (job_valid && !out_valid_ff) begin
               job_pop = 1'b1;
               if (job_overflow) begin
                  fin    = 1'b1;
                  fin_st = ST_OVERFLOW;
               end else begin
                  size_in  = job_length;
                  bit_in   = TOP_FLAG_BIT;
                  state_in = W_SCAN;
               end
            end
         end
         W_SCAN: begin
            if (flags[bit_ff]) begin
               k_in     = K_W'(1);
               te_in    = '0;
               state_in = W_VREAD;
            end else if (bit_ff == LAST_ENTRY_BIT) begin
               state_in = W_OVL;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         W_VREAD: begin
            if (32'(k_ff) > 32'(size_ff)) begin
               fin    = 1'b1;
               fin_st = ST_BEFORE_START;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(size_ff - LEN_W'(k_ff));
               state_in = W_VUSE;
            end
         end
         W_VUSE: begin
            te_in = te_next;
            if (rd_data[VARINT_END_BIT] || (32'(k_ff) == MAX_VARINT_BYTES)) begin
               state_in = W_VCHECK;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = W_VREAD;
            end
         end
         W_VCHECK: begin
            if (CMP_W'(te_ff) > CMP_W'(size_ff)) begin
               fin    = 1'b1;
               fin_st = ST_TRAILER_LONG;
            end else begin
               size_in = LEN_W'(CMP_W'(size_ff) - CMP_W'(te_ff));
               if (bit_ff == LAST_ENTRY_BIT) begin
                  state_in = W_OVL;
               end else begin
                  bit_in   = bit_ff - 1'b1;
                  state_in = W_SCAN;
               end
            end
         end
         W_OVL: begin
            if (!flags[OVERLAP_FLAG_BIT]) begin
               fin = 1'b1;
            end else if (size_ff == '0) begin
               fin    = 1'b1;
               fin_st = ST_BEFORE_START;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(size_ff - 1'b1);
               state_in = W_OVL_USE;
            end
         end
         W_OVL_USE: begin
            fin = 1'b1;
            if (32'(rd_data[OVERLAP_W-1:0]) + 1 > 32'(size_ff)) begin
               fin_st = ST_TRAILER_LONG;
            end else begin
               fin_size = size_ff - LEN_W'(rd_data[OVERLAP_W-1:0]) - 1'b1;
               fin_ovl  = rd_data[OVERLAP_W-1:0];
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      out_len_in   = out_len_ff;
      out_ovl_in   = out_ovl_ff;
      out_st_in    = out_st_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (fin) begin
         state_in     = W_IDLE;
         out_valid_in = 1'b1;
         out_st_in    = fin_st;
         out_len_in   = (fin_st == ST_OK) ? PAYLOAD_W'(32'(fin_size)) : '0;
         out_ovl_in   = (fin_st == ST_OK) ? fin_ovl : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff     <= bit_in;
      size_ff    <= size_in;
      te_ff      <= te_in;
      k_ff       <= k_in;
      out_len_ff <= out_len_in;
      out_ovl_ff <= out_ovl_in;
      out_st_ff  <= out_st_in;
   end

   assign walk_idle          = (state_ff == W_IDLE);
   assign rsp_valid          = out_valid_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_overlap_length = out_ovl_ff;
   assign rsp_status         = out_st_ff;

endmodule

@@ rtl/core/record_trailer_strip_top.sv @@
// ----------------------------------------------------------------------------
// record_trailer_strip_top
// Strips trailing entries and the multibyte overlap entry from a text record.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one record byte per transaction (req_data_byte), with
//   req_last_byte marking the final byte. Bytes are taken one per cycle while req_stall is low.
//   rsp_ channel: one transaction per record, after its last byte, carrying
//   payload_length, overlap_length and status.
//   csr_ port: csr_write_enable writes csr_write_data into the trailer flag
//   register; write it only while no record is in flight.
// Stall after a record:
//   After the last byte req_stall rises while the walker reads the record
//   end from the store: it takes the job, scans the flag bits from 15 down
//   to 1, reads each varint byte in a read state and a use state, checks
//   each present entry, and reads the overlap byte if flag bit 0 is set.
//   An overflowed record ends the walk as soon as its job is taken.
//   req_stall drops in the cycle after rsp_valid rises.
//   The walk reads the store one byte at a time through its single read port.
//   The result then sits in an output register, so the next record may load
//   while it waits to be taken.
// Reset: clears the length count, the overflow mark, the flags and all
//   control state; the store needs no clearing pass.
// A stalled rsp_ transaction holds; the walker takes no new job until then.
// ----------------------------------------------------------------------------
module record_trailer_strip_top #(
   parameter int RECORD_BYTES     = rts_pkg::RECORD_BYTES_DEF,
   parameter int MAX_VARINT_BYTES = rts_pkg::MAX_VARINT_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rts_pkg::PAYLOAD_W-1:0] rsp_payload_length,
   output logic [rts_pkg::OVERLAP_W-1:0] rsp_overlap_length,
   output logic [rts_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                          csr_write_enable,
   input  logic [rts_pkg::FLAGS_W-1:0]   csr_write_data
);
   import rts_pkg::*;

   localparam int LEN_W  = $clog2(RECORD_BYTES + 1);
   localparam int ADDR_W = $clog2(RECORD_BYTES);
   localparam int JOB_W  = LEN_W + 1;

   // trailer flag register
   logic [FLAGS_W-1:0] flags_ff, flags_in;

   // store write side (front) and read side (back)
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        wr_data, rd_data;

   // job queue
   logic              job_push, job_pop;
   logic [LEN_W-1:0]  push_length;
   logic              push_overflow;
   logic [JOB_W-1:0]  pop_data;
   logic              queue_empty, queue_full;
   logic              walk_idle;
   status_type        status;

   assign flags_in = csr_write_enable ? csr_write_data : flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // front: accept bytes, write them away, queue a job on the last byte
   rts_loader #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_loader (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .job_push     (job_push),
      .job_length   (push_length),
      .job_overflow (push_overflow),
      .queue_empty  (queue_empty),
      .walk_idle    (walk_idle)
   );

   rts_store #(
      .RECORD_BYTES(RECORD_BYTES)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // pack overflow mark above the record length
   rts_job_fifo #(
      .WIDTH(JOB_W),
      .DEPTH(JOB_QUEUE_DEPTH)
   ) u_job_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data({push_overflow, push_length}),
      .pop      (job_pop),
      .pop_data (pop_data),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // back: walk the record end and drive the result register
   rts_walker #(
      .RECORD_BYTES    (RECORD_BYTES),
      .MAX_VARINT_BYTES(MAX_VARINT_BYTES)
   ) u_walker (
      .clock             (clock),
      .reset             (reset),
      .flags             (flags_ff),
      .job_valid         (!queue_empty),
      .job_length        (pop_data[LEN_W-1:0]),
      .job_overflow      (pop_data[LEN_W]),
      .job_pop           (job_pop),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .walk_idle         (walk_idle),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload_length(rsp_payload_length),
      .rsp_overlap_length(rsp_overlap_length),
      .rsp_status        (status)
   );

   assign rsp_status = status;

`ifndef SYNTHESIS
   // the front must hold off after a last byte until the walk is done
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_last_byte) |=> req_stall)
      else $error("new byte taken while record walk pending");

   // a job is never pushed into a full queue
   assert property (@(posedge clock) disable iff (reset)
      job_push |-> !queue_full)
      else $error("job pushed into full queue");

   // an error result carries no lengths
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status != ST_OK) |->
         (rsp_payload_length == '0 && rsp_overlap_length == '0))
      else $error("error result with nonzero length");

   // the store is never written while the walker reads it
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("store written during walk");
`endif

endmodule

@@ verif/tb_record_trailer_strip_top.sv @@
// ----------------------------------------------------------------------------
// tb_record_trailer_strip_top
// Self-checking bench for the record trailer strip block.
// ----------------------------------------------------------------------------
// A short table of hand-built records covers the special cases: the overlap
// entry, varints that run off the record start, an unterminated varint and
// every flag extreme. Random records follow, mostly well-formed with random
// trailer sizes and content, the rest damaged or pure noise. Each record's
// result is taken from the table or predicted from a shadow copy of the record
// and the flag register, then compared field by field with the rsp_
// transactions as they are taken. Sender gaps and receiver stalls vary by
// phase, and the flag register is rewritten between phases once idle.
// ----------------------------------------------------------------------------
module tb_record_trailer_strip_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rts_pkg::*;

   localparam int RECORD_BYTES     = RECORD_BYTES_DEF;
   localparam int MAX_VARINT_BYTES = MAX_VARINT_BYTES_DEF;
   // let the walk finish before a flag write
   localparam int WALK_SETTLE_CYCLES = 250;
   localparam int RUN_LIMIT_NS       = 5_000_000;
   localparam int PHASE_COUNT        = 12;
   localparam int PHASE_ITEM_TARGET  = 35;
   localparam int PHASE_RECORD_MIN   = 1;

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload_len;
      logic [OVERLAP_W-1:0] overlap_len;
      status_type           status;
   } record_result_type;

   // one hand-built record: bytes holds the last n bytes, read left to right,
   // after pad random leading bytes
   typedef struct packed {
      logic [FLAGS_W-1:0]   flags;
      logic [13:0]          pad;
      logic [3:0]           n;
      logic [63:0]          bytes;
      logic                 known;
      logic [PAYLOAD_W-1:0] e_len;
      logic [OVERLAP_W-1:0] e_ovl;
      status_type           e_status;
   } directed_record_type;

   typedef enum logic [1:0] {
      DAMAGE_NOISE,
      DAMAGE_TRUNCATE,
      DAMAGE_OPEN_VARINT,
      DAMAGE_BIT_FLIP
   } damage_kind_type;

   localparam int DIRECTED_COUNT = 13;

   directed_record_type directed_records [DIRECTED_COUNT] = '{
      // flags reset value: no trailers, the whole record is payload
      '{16'h0000, 14'd0,    4'd1, 64'h00,             1'b1, 14'd1,    2'd0, ST_OK},
      '{16'h0000, 14'd0,    4'd1, 64'hFF,             1'b1, 14'd1,    2'd0, ST_OK},
      // overlap entry only: largest count, count too big, count zero
      '{16'h0001, 14'd0,    4'd4, 64'hAA_BB_CC_03,    1'b1, 14'd0,    2'd3, ST_OK},
      '{16'h0001, 14'd0,    4'd1, 64'h02,             1'b1, 14'd0,    2'd0, ST_TRAILER_LONG},
      '{16'h0001, 14'd0,    4'd2, 64'h5A_00,          1'b1, 14'd1,    2'd0, ST_OK},
      // top entry: varint runs off the record start, then exact fit
      '{16'h8000, 14'd0,    4'd1, 64'h01,             1'b1, 14'd0,    2'd0, ST_BEFORE_START},
      '{16'h8000, 14'd0,    4'd3, 64'h11_22_83,       1'b1, 14'd0,    2'd0, ST_OK},
      // unterminated varint: the cap must stop the read before the first byte
      '{16'h8000, 14'd0,    4'd6, 64'hFF_00_00_00_00_00, 1'b0, 14'd0, 2'd0, ST_OK},
      '{16'h8000, 14'd0,    4'd3, 64'h01_80_03,       1'b0, 14'd0,    2'd0, ST_OK},
      // two-byte varint larger than the record
      '{16'h0002, 14'd0,    4'd2, 64'h81_00,          1'b1, 14'd0,    2'd0, ST_TRAILER_LONG},
      // entry eats the record, overlap byte then lies before the start
      '{16'h0003, 14'd0,    4'd1, 64'h81,             1'b1, 14'd0,    2'd0, ST_BEFORE_START},
      '{16'h8001, 14'd0,    4'd5, 64'h41_42_01_99_82, 1'b0, 14'd0,    2'd0, ST_OK},
      // every flag set, zero-length entries all read the same byte
      '{16'hFFFF, 14'd0,    4'd1, 64'h80,             1'b1, 14'd0,    2'd0, ST_OK}
   };

   localparam logic [FLAGS_W-1:0] PHASE_FLAGS [8] = '{
      16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h0002, 16'h8001, 16'h5555, 16'hAAAA
   };
   // sender idle and receiver stall percentages per idling mode
   localparam int SEND_IDLE_PCT [4] = '{0, 72, 0, 35};
   localparam int RECV_STALL_PCT [4] = '{0, 0, 72, 35};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PAYLOAD_W-1:0] rsp_payload_length;
   logic [OVERLAP_W-1:0] rsp_overlap_length;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_write_enable = 1'b0;
   logic [FLAGS_W-1:0]   csr_write_data = '0;

   // shadow of the block: flag register and the record being loaded
   logic [FLAGS_W-1:0]   shadow_flags;
   logic [7:0]           shadow_store [RECORD_BYTES];
   int unsigned          shadow_len;
   bit                   shadow_overflow;

   record_result_type    expected_results [$];
   logic [7:0]           record_bytes [$];

   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   error_count = 0;
   int                   records_sent = 0;
   int                   bytes_sent = 0;
   int                   flag_writes = 0;
   int                   status_seen [4] = '{0, 0, 0, 0};

   record_trailer_strip_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_length (rsp_payload_length),
      .rsp_overlap_length (rsp_overlap_length),
      .rsp_status         (rsp_status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #5 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Store one accepted byte; bytes past the buffer are dropped and marked.
   function automatic void shadow_load(input logic [7:0] b);
      if (shadow_len < RECORD_BYTES) begin
         shadow_store[shadow_len] = b;
         shadow_len++;
      end else begin
         shadow_overflow = 1'b1;
      end
   endfunction

   // Walk back from the record end, peel off each flagged entry, then the
   // overlap entry. Any error leaves both lengths at zero.
   function automatic record_result_type strip_trailers();
      record_result_type r;
      longint unsigned   remaining;
      longint unsigned   entry_len;
      longint unsigned   digit;
      int                bit_idx;
      int                k;
      logic [7:0]        ch;
      logic [1:0]        ov;

      r.payload_len = '0;
      r.overlap_len = '0;
      r.status      = ST_OK;
      remaining     = shadow_len;
      if (shadow_overflow) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      for (bit_idx = int'(TOP_FLAG_BIT); bit_idx >= int'(LAST_ENTRY_BIT); bit_idx--) begin
         if (shadow_flags[bit_idx]) begin
            entry_len = 0;
            for (k = 1; k <= MAX_VARINT_BYTES; k++) begin
               if (k > remaining) begin
                  r.status = ST_BEFORE_START;
                  return r;
               end
               ch        = shadow_store[remaining - k];
               digit     = ch[VARINT_DIGIT_W-1:0];
               entry_len = entry_len | (digit << (VARINT_DIGIT_W * (k - 1)));
               if (ch[VARINT_END_BIT]) break;
            end
            if (entry_len > remaining) begin
               r.status = ST_TRAILER_LONG;
               return r;
            end
            remaining = remaining - entry_len;
         end
      end
      if (shadow_flags[OVERLAP_FLAG_BIT]) begin
         if (remaining == 0) begin
            r.status = ST_BEFORE_START;
            return r;
         end
         ov = shadow_store[remaining - 1][1:0];
         if (ov + 1 > remaining) begin
            r.status = ST_TRAILER_LONG;
            return r;
         end
         remaining     = remaining - (ov + 1);
         r.overlap_len = ov;
      end
      r.payload_len = remaining[PAYLOAD_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Record building
   // ------------------------------------------------------------------------

   // Well-formed record: payload, overlap bytes and overlap byte, then the
   // entries for bits 1 to 15 so that bit 15's entry ends the record. Each
   // varint counts its own bytes.
   function automatic void compose_record(input logic [FLAGS_W-1:0] flags);
      int         plen;
      int         ov;
      int         entry_len;
      int         bit_idx;

      record_bytes.delete();
      plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 10);
      repeat (plen) record_bytes.push_back(8'($urandom));
      if (flags[OVERLAP_FLAG_BIT]) begin
         ov = $urandom_range(0, 3);
         repeat (ov) record_bytes.push_back(8'($urandom));
         record_bytes.push_back({6'($urandom), 2'(ov)});
      end
      for (bit_idx = int'(LAST_ENTRY_BIT); bit_idx <= int'(TOP_FLAG_BIT); bit_idx++) begin
         if (flags[bit_idx]) begin
            if ($urandom_range(0, 63) == 0) begin
               // two-byte varint, most significant digit first in the file
               entry_len = $urandom_range(128, 170);
               repeat (entry_len - 2) record_bytes.push_back(8'($urandom));
               record_bytes.push_back(8'h80 | 8'(entry_len >> 7));
               record_bytes.push_back(8'(entry_len) & 8'h7F);
            end else begin
               entry_len = $urandom_range(1, 4);
               repeat (entry_len - 1) record_bytes.push_back(8'($urandom));
               record_bytes.push_back(8'h80 | 8'(entry_len));
            end
         end
      end
      if (record_bytes.size() == 0) record_bytes.push_back(8'($urandom));
   endfunction

   // Damage the record so that the error paths and odd walks get exercised.
   function automatic void damage_record();
      damage_kind_type kind;
      int              count;
      int              idx;

      kind = damage_kind_type'($urandom_range(0, 3));
      case (kind)
         DAMAGE_NOISE: begin
            record_bytes.delete();
            count = $urandom_range(1, 24);
            repeat (count) record_bytes.push_back(8'($urandom));
         end
         DAMAGE_TRUNCATE: begin
            if (record_bytes.size() > 1) begin
               count = $urandom_range(1, record_bytes.size() - 1);
               repeat (count) void'(record_bytes.pop_front());
            end
         end
         DAMAGE_OPEN_VARINT: begin
            idx = record_bytes.size() - 1;
            record_bytes[idx] = record_bytes[idx] & 8'h7F;
         end
         DAMAGE_BIT_FLIP: begin
            idx = $urandom_range(0, record_bytes.size() - 1);
            record_bytes[idx] = record_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------

   // Offer one byte, idling first at random, and hold it until taken.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow_load(b);
      bytes_sent++;
   endtask

   // Send record_bytes; on the last byte queue either the typed-in result or
   // the predicted one, then clear the shadow record.
   task automatic send_record(input bit use_typed, input record_result_type typed_result);
      record_result_type predicted;
      int                j;

      for (j = 0; j < record_bytes.size(); j++)
         send_byte(record_bytes[j], j == record_bytes.size() - 1);
      predicted = strip_trailers();
      expected_results.push_back(use_typed ? typed_result : predicted);
      shadow_len      = 0;
      shadow_overflow = 1'b0;
      records_sent++;
   endtask

   // Hold the sender until every result is back, optionally letting the
   // walker settle afterwards.
   task automatic drain_results(input bit settle);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      if (settle) repeat (WALK_SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_flags(input logic [FLAGS_W-1:0] value);
      drain_results(1'b1);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_flags = value;
      flag_writes++;
   endtask

   // ------------------------------------------------------------------------
   // Checking: every taken rsp_ transaction against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_check
      record_result_type head;

      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[rsp_status]++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: payload_length %0d overlap_length %0d status %0d",
                     $time, rsp_payload_length, rsp_overlap_length, rsp_status);
            error_count++;
         end else begin
            head = expected_results.pop_front();
            if (rsp_payload_length !== head.payload_len) begin
               $display("%0t: payload_length expected %0d actual %0d",
                        $time, head.payload_len, rsp_payload_length);
               error_count++;
            end
            if (rsp_overlap_length !== head.overlap_len) begin
               $display("%0t: overlap_length expected %0d actual %0d",
                        $time, head.overlap_len, rsp_overlap_length);
               error_count++;
            end
            if (rsp_status !== head.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, head.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      directed_record_type row;
      record_result_type   typed_result;
      logic [FLAGS_W-1:0]  phase_flags;
      int                  i;
      int                  j;
      int                  phase;
      int                  phase_items;
      int                  phase_records;

      shadow_flags    = '0;
      shadow_len      = 0;
      shadow_overflow = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed records, no idling; rewrite the flags only when they change
      for (i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_records[i];
         if (i == 0 || row.flags != shadow_flags) write_flags(row.flags);
         record_bytes.delete();
         repeat (row.pad) record_bytes.push_back(8'($urandom));
         for (j = 0; j < row.n; j++) record_bytes.push_back(row.bytes[8 * (row.n - 1 - j) +: 8]);
         typed_result.payload_len = row.e_len;
         typed_result.overlap_len = row.e_ovl;
         typed_result.status      = row.e_status;
         send_record(row.known, typed_result);
      end

      // random phases: fixed flag patterns first, then random ones, while the
      // idling mode cycles through its four settings
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         phase_flags = (phase < 8) ? PHASE_FLAGS[phase] : 16'($urandom_range(0, 16'hFFFF));
         write_flags(phase_flags);
         send_idle_pct  = SEND_IDLE_PCT[phase % 4];
         recv_stall_pct = RECV_STALL_PCT[phase % 4];
         phase_items    = 0;
         phase_records  = 0;
         while (phase_items < PHASE_ITEM_TARGET || phase_records < PHASE_RECORD_MIN) begin
            compose_record(phase_flags);
            if ($urandom_range(0, 4) == 0) damage_record();
            phase_items += record_bytes.size();
            send_record(1'b0, typed_result);
            phase_records++;
            // now and then hold the sender until the block has caught up
            if ($urandom_range(0, 9) == 0) drain_results(1'b0);
         end
      end

      drain_results(1'b1);
      $display("Covered %0d records (%0d bytes) over %0d flag settings.",
               records_sent, bytes_sent, flag_writes);
      $display("Statuses seen: ok %0d, trailer too long %0d, before start %0d, overflow %0d.",
               status_seen[ST_OK], status_seen[ST_TRAILER_LONG],
               status_seen[ST_BEFORE_START], status_seen[ST_OVERFLOW]);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule
